// ===== rtl/mphd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mphd_pkg
// Shared types, field widths and codes of the peak hold bar meter block.
// ----------------------------------------------------------------------------
package mphd_pkg;

  localparam int NumMetersDef = 6;
  localparam int LevelBitsDef = 16;
  localparam int HoldBitsDef  = 8;

  localparam int ChanW       = 3;
  localparam int LevelW      = 16;
  localparam int HoldTicksW  = 8;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;
  localparam int InDataW     = 24;
  localparam int OutDataW    = 40;

  localparam logic [LevelW-1:0]     DecayStepRst     = 16'd1311;
  localparam logic [LevelW-1:0]     PeakDecayStepRst = 16'd655;
  localparam logic [HoldTicksW-1:0] PeakHoldTicksRst = 8'd20;

  typedef enum logic {
    FuncReading = 1'b0,
    FuncTick    = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDecayStep     = 2'd0,
    CfgPeakDecayStep = 2'd1,
    CfgPeakHoldTicks = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    StIdle,
    StUpdate
  } state_e;

endpackage

// ===== rtl/mphd_state_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mphd_state_ram
// Per-meter state memory, one write and one registered read port. Entries
// read as zero until first written.
// ----------------------------------------------------------------------------
module mphd_state_ram #(
  parameter int Depth = 6,
  parameter int Width = 56,
  parameter int AddrW = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/mphd_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mphd_update
// Ballistics of one meter: applies a reading or one decay tick to a state
// entry and reports whether anything moved (always flagged for a reading).
// ----------------------------------------------------------------------------
module mphd_update #(
  parameter int LevelBits = 16,
  parameter int HoldBits  = 8,
  parameter int EntryW    = 56
) (
  input  mphd_pkg::func_e                      func_i,
  input  logic [LevelBits-1:0]                 level_i,
  input  logic [mphd_pkg::LevelW-1:0]          decay_step_i,
  input  logic [mphd_pkg::LevelW-1:0]          peak_decay_step_i,
  input  logic [mphd_pkg::HoldTicksW-1:0]      peak_hold_ticks_i,
  input  logic [EntryW-1:0]                    entry_i,
  output logic [EntryW-1:0]                    entry_o,
  output logic                                 changed_o
);
  import mphd_pkg::*;

  localparam int HoldMax = (1 << HoldBits) - 1;

  logic [LevelBits-1:0] tgt, disp, peak, disp_n, peak_n, tgt_n;
  logic [LevelBits-1:0] st, pst, ddiff, pdiff;
  logic [HoldBits-1:0]  hold, hold_n, hold_load;

  assign tgt  = entry_i[LevelBits-1:0];
  assign disp = entry_i[2*LevelBits-1:LevelBits];
  assign peak = entry_i[3*LevelBits-1:2*LevelBits];
  assign hold = entry_i[3*LevelBits+HoldBits-1:3*LevelBits];

  assign st  = LevelBits'(decay_step_i);
  assign pst = LevelBits'(peak_decay_step_i);
  assign hold_load = (32'(peak_hold_ticks_i) > HoldMax) ? HoldBits'(HoldMax)
                                                         : HoldBits'(peak_hold_ticks_i);

  always_comb begin
    tgt_n     = tgt;
    disp_n    = disp;
    peak_n    = peak;
    hold_n    = hold;
    changed_o = 1'b0;
    ddiff     = disp - tgt;
    pdiff     = '0;
    case (func_i)
      FuncReading: begin
        tgt_n     = level_i;
        changed_o = 1'b1;
        if (level_i > disp) begin
          disp_n = level_i;
        end
        if (level_i > peak) begin
          peak_n = level_i;
          hold_n = hold_load;
        end
      end
      FuncTick: begin
        if (disp > tgt) begin
          disp_n    = (ddiff <= st) ? tgt : disp - st;
          changed_o = 1'b1;
        end
        pdiff = peak - disp_n;
        if (peak > disp_n) begin
          changed_o = 1'b1;
          if (hold != '0) begin
            hold_n = hold - 1'b1;
          end else begin
            peak_n = (pdiff <= pst) ? disp_n : peak - pst;
          end
        end
      end
      default: begin
        changed_o = 1'b0;
      end
    endcase
  end

  assign entry_o = {hold_n, peak_n, disp_n, tgt_n};

endmodule

// ===== rtl/meter_peak_hold_decay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_peak_hold_decay
// Bar and peak marker ballistics for a bank of level meters.
//
// Input words carry a reading (tuser low: channel and level in tdata) or a
// decay tick (tuser high). A reading updates one meter and returns one word;
// a reading for an absent meter is dropped with no word. A tick walks every
// meter in ascending order and returns one word per meter, tlast on the
// final one. Output words hold meter index, bar and peak in tdata, a changed
// flag in tuser.
// A word is taken only when the block is idle; unless it is dropped, the state
// memory read for it is issued in that same cycle. A reading then does one
// read-modify-write of the state memory, and a tick one per meter.
// The output register lets the next input word be taken while a result still
// waits; a stalled receiver holds the walk in place without loss.
// Reset clears all meter state to zero and loads the default steps and hold.
// Configuration writes take effect at once; the user must make them while idle (not enforced).
// ----------------------------------------------------------------------------
module meter_peak_hold_decay #(
  parameter int NUM_METERS = mphd_pkg::NumMetersDef,
  parameter int LEVEL_BITS = mphd_pkg::LevelBitsDef,
  parameter int HOLD_BITS  = mphd_pkg::HoldBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mphd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mphd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mphd_pkg::InDataW-1:0]     s_axis_tdata,  // channel, level
  input  logic                             s_axis_tuser,  // func
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mphd_pkg::OutDataW-1:0]    m_axis_tdata,  // meter_index, shown_level, peak_mark
  output logic                             m_axis_tuser,  // changed
  output logic                             m_axis_tlast
);
  import mphd_pkg::*;

  localparam int AddrW  = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;
  localparam int EntryW = 3 * LEVEL_BITS + HOLD_BITS;

  state_e                 state_q, state_d;
  func_e                  func_q;
  logic [LEVEL_BITS-1:0]  level_q;
  logic [AddrW-1:0]       meter_q;
  logic [LevelW-1:0]      decay_step_q, peak_decay_step_q;
  logic [HoldTicksW-1:0]  peak_hold_ticks_q;

  logic                   out_valid_q, out_chg_q, out_last_q;
  logic [ChanW-1:0]       out_idx_q;
  logic [LevelW-1:0]      out_disp_q, out_peak_q;

  logic [ChanW-1:0]       in_chan;
  logic [LevelW-1:0]      in_level;
  func_e                  in_func;
  logic                   in_acc, in_go, can_emit, item_last;
  logic                   rd_en, wr_en, changed;
  logic [AddrW-1:0]       rd_addr;
  logic [EntryW-1:0]      rd_entry, wr_entry;

  assign in_chan  = s_axis_tdata[ChanW-1:0];
  assign in_level = s_axis_tdata[ChanW+LevelW-1:ChanW];
  assign in_func  = func_e'(s_axis_tuser);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_go) state_d = StUpdate;
      end
      StUpdate: begin
        if (can_emit && item_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_axis_tready = (state_q == StIdle);
    in_acc        = s_axis_tvalid && s_axis_tready;
    in_go         = in_acc && (in_func == FuncTick || 32'(in_chan) < NUM_METERS);
    can_emit      = !out_valid_q || m_axis_tready;
    item_last     = (func_q == FuncReading) || (meter_q == AddrW'(NUM_METERS - 1));
    wr_en         = (state_q == StUpdate) && can_emit;
    rd_en         = 1'b0;
    rd_addr       = meter_q + AddrW'(1);
    case (state_q)
      StIdle: begin
        rd_en   = in_go;
        rd_addr = (in_func == FuncTick) ? '0 : AddrW'(in_chan);
      end
      StUpdate: begin
        rd_en = can_emit && !item_last;
      end
      default: rd_en = 1'b0;
    endcase
  end

  mphd_state_ram #(
    .Depth (NUM_METERS),
    .Width (EntryW),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry),
    .wr_en_i   (wr_en),
    .wr_addr_i (meter_q),
    .wr_data_i (wr_entry)
  );

  mphd_update #(
    .LevelBits (LEVEL_BITS),
    .HoldBits  (HOLD_BITS),
    .EntryW    (EntryW)
  ) u_update (
    .func_i            (func_q),
    .level_i           (level_q),
    .decay_step_i      (decay_step_q),
    .peak_decay_step_i (peak_decay_step_q),
    .peak_hold_ticks_i (peak_hold_ticks_q),
    .entry_i           (rd_entry),
    .entry_o           (wr_entry),
    .changed_o         (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= in_func;
      level_q <= LEVEL_BITS'(in_level);
    end
    if (rd_en) begin
      meter_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_step_q      <= DecayStepRst;
      peak_decay_step_q <= PeakDecayStepRst;
      peak_hold_ticks_q <= PeakHoldTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDecayStep:     decay_step_q      <= cfg_wdata_i;
        CfgPeakDecayStep: peak_decay_step_q <= cfg_wdata_i;
        CfgPeakHoldTicks: peak_hold_ticks_q <= cfg_wdata_i[HoldTicksW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_idx_q  <= ChanW'(meter_q);
      out_disp_q <= LevelW'(wr_entry[2*LEVEL_BITS-1:LEVEL_BITS]);
      out_peak_q <= LevelW'(wr_entry[3*LEVEL_BITS-1:2*LEVEL_BITS]);
      out_chg_q  <= changed;
      out_last_q <= item_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - ChanW - 2 * LevelW)'(0), out_peak_q, out_disp_q, out_idx_q};
  assign m_axis_tuser  = out_chg_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the peak hold bar meter block.
//
// A directed table covers the extremes of the level, absent meters, ticks and
// register changes (zero steps, full steps, zero and full hold). Random phases
// follow under several register settings and idle patterns on both streams.
// Every accepted input word runs through a behavioral model of the meter
// bank, and each output word is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
  import mphd_pkg::*;

  localparam int NumMeters  = NumMetersDef;
  localparam int SettleCyc  = 20;
  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 50;

  typedef logic [LevelW-1:0]     level_t;
  typedef logic [HoldTicksW-1:0] hold_t;

  typedef struct packed {
    logic [ChanW-1:0] meter;
    level_t           bar;
    level_t           peak;
    logic             changed;
    logic             last;
  } meter_word_t;

  typedef enum logic {
    RowWord,
    RowReg
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    func_e            func;
    logic [ChanW-1:0] chan;
    level_t           value;
    cfg_idx_e         reg_idx;
    logic             typed;
    level_t           bar;
    level_t           peak;
  } row_t;

  typedef struct packed {
    level_t decay;
    level_t peak_decay;
    hold_t  hold;
  } meter_regs_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic [InDataW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tready = 1'b0;
  logic s_tready;
  logic m_tvalid;
  logic [OutDataW-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  meter_peak_hold_decay dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // meter bank model
  level_t target_lvl [NumMeters];
  level_t bar_lvl    [NumMeters];
  level_t peak_lvl   [NumMeters];
  hold_t  hold_cnt   [NumMeters];
  meter_regs_t regs_m;

  meter_word_t meter_q [$];
  int errors = 0;
  int n_results = 0;
  int n_ticks = 0;
  int n_readings = 0;
  int n_dropped = 0;
  int n_settings = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;

  // behavior of one accepted word
  task automatic predict_meters(input func_e func, input logic [ChanW-1:0] chan,
                                input level_t lvl);
    meter_word_t w;
    logic chg;
    if (func == FuncReading) begin
      if (chan >= NumMeters) begin
        n_dropped++;
        return;
      end
      n_readings++;
      target_lvl[chan] = lvl;
      if (lvl > bar_lvl[chan]) bar_lvl[chan] = lvl;
      if (lvl > peak_lvl[chan]) begin
        peak_lvl[chan] = lvl;
        hold_cnt[chan] = regs_m.hold;
      end
      w = '{meter: chan, bar: bar_lvl[chan], peak: peak_lvl[chan], changed: 1'b1,
            last: 1'b1};
      meter_q.push_back(w);
    end else begin
      n_ticks++;
      for (int m = 0; m < NumMeters; m++) begin
        chg = 1'b0;
        if (bar_lvl[m] > target_lvl[m]) begin
          if (bar_lvl[m] - target_lvl[m] <= regs_m.decay) bar_lvl[m] = target_lvl[m];
          else bar_lvl[m] = bar_lvl[m] - regs_m.decay;
          chg = 1'b1;
        end
        if (peak_lvl[m] > bar_lvl[m]) begin
          if (hold_cnt[m] > 0) hold_cnt[m] = hold_cnt[m] - 1'b1;
          else if (peak_lvl[m] - bar_lvl[m] <= regs_m.peak_decay) peak_lvl[m] = bar_lvl[m];
          else peak_lvl[m] = peak_lvl[m] - regs_m.peak_decay;
          chg = 1'b1;
        end
        w = '{meter: m[ChanW-1:0], bar: bar_lvl[m], peak: peak_lvl[m], changed: chg,
              last: (m == NumMeters - 1)};
        meter_q.push_back(w);
      end
    end
  endtask

  task automatic send_word(input func_e func, input logic [ChanW-1:0] chan,
                           input level_t lvl);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW - LevelW - ChanW){1'b0}}, lvl, chan};
    s_tuser  <= func;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_meters(func, chan, lvl);
  endtask

  // block is quiet: nothing owed, and time for a dropped reading to finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    cfg_we   <= 1'b0;
    @(posedge clk_i);
    while (meter_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input level_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CfgDecayStep:     regs_m.decay      = val;
      CfgPeakDecayStep: regs_m.peak_decay = val;
      CfgPeakHoldTicks: regs_m.hold       = val[HoldTicksW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_regs(input meter_regs_t r);
    wait_idle();
    write_reg(CfgDecayStep, r.decay);
    write_reg(CfgPeakDecayStep, r.peak_decay);
    write_reg(CfgPeakHoldTicks, {{(LevelW - HoldTicksW){1'b0}}, r.hold});
    n_settings++;
  endtask

  // mostly readings, some near the current bar or at the extremes, with ticks and a few absent meters
  task automatic send_random();
    logic [ChanW-1:0] chan;
    level_t lvl;
    int pick;
    int delta;
    lvl = level_t'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 30) begin
      send_word(FuncTick, ChanW'($urandom_range(7)), lvl);
      return;
    end
    chan = ($urandom_range(19) == 0) ? ChanW'($urandom_range(7, NumMeters))
                                     : ChanW'($urandom_range(NumMeters - 1));
    pick = $urandom_range(99);
    if (pick < 10) lvl = '0;
    else if (pick < 20) lvl = '1;
    else if (pick < 55 && chan < NumMeters) begin
      delta = $urandom_range(6000) - 3000;
      delta = delta + bar_lvl[chan];
      lvl = (delta < 0) ? '0 : (delta > 16'hFFFF) ? '1 : delta[LevelW-1:0];
    end
    send_word(FuncReading, chan, lvl);
  endtask

  row_t dir_rows [0:22] = '{
    '{RowWord, FuncReading, 3'd0, 16'hFFFF, CfgDecayStep, 1'b1, 16'hFFFF, 16'hFFFF},
    '{RowWord, FuncReading, 3'd5, 16'h0000, CfgDecayStep, 1'b1, 16'h0000, 16'h0000},
    '{RowWord, FuncReading, 3'd6, 16'h1234, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowWord, FuncReading, 3'd7, 16'hFFFF, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowWord, FuncTick,    3'd7, 16'hFFFF, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowWord, FuncReading, 3'd1, 16'h8000, CfgDecayStep, 1'b1, 16'h8000, 16'h8000},
    '{RowWord, FuncReading, 3'd1, 16'h0000, CfgDecayStep, 1'b1, 16'h8000, 16'h8000},
    '{RowWord, FuncReading, 3'd2, 16'h5555, CfgDecayStep, 1'b1, 16'h5555, 16'h5555},
    '{RowWord, FuncReading, 3'd3, 16'hAAAA, CfgDecayStep, 1'b1, 16'hAAAA, 16'hAAAA},
    '{RowWord, FuncTick,    3'd0, 16'h0000, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowReg,  FuncReading, 3'd0, 16'h0000, CfgPeakHoldTicks, 1'b0, 16'h0000, 16'h0000},
    '{RowReg,  FuncReading, 3'd0, 16'hFFFF, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowWord, FuncReading, 3'd4, 16'hF000, CfgDecayStep, 1'b1, 16'hF000, 16'hF000},
    '{RowWord, FuncReading, 3'd4, 16'h1000, CfgDecayStep, 1'b1, 16'hF000, 16'hF000},
    '{RowWord, FuncTick,    3'd2, 16'h0F0F, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowReg,  FuncReading, 3'd0, 16'h0000, CfgPeakDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowReg,  FuncReading, 3'd0, 16'h0000, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowWord, FuncTick,    3'd5, 16'hF0F0, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowReg,  FuncReading, 3'd0, 16'hFFFF, CfgPeakDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowWord, FuncTick,    3'd1, 16'h0000, CfgDecayStep, 1'b0, 16'h0000, 16'h0000},
    '{RowReg,  FuncReading, 3'd0, 16'h00FF, CfgPeakHoldTicks, 1'b0, 16'h0000, 16'h0000},
    '{RowWord, FuncReading, 3'd5, 16'hFFFF, CfgDecayStep, 1'b1, 16'hFFFF, 16'hFFFF},
    '{RowWord, FuncTick,    3'd3, 16'h0000, CfgDecayStep, 1'b0, 16'h0000, 16'h0000}
  };

  meter_regs_t phase_regs [5];
  int phase_send [5] = '{0, 74, 0, 32, 0};
  int phase_recv [5] = '{0, 0, 74, 32, 0};

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  meter_word_t got;
  meter_word_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{meter: m_tdata[ChanW-1:0], bar: m_tdata[ChanW +: LevelW],
              peak: m_tdata[ChanW + LevelW +: LevelW], changed: m_tuser, last: m_tlast};
      n_results++;
      if (meter_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word meter %0d bar %h peak %h changed %b last %b",
                 $time, got.meter, got.bar, got.peak, got.changed, got.last);
      end else begin
        want = meter_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected meter %0d bar %h peak %h changed %b last %b", $time,
                   want.meter, want.bar, want.peak, want.changed, want.last);
          $display("%0t: actual   meter %0d bar %h peak %h changed %b last %b", $time,
                   got.meter, got.bar, got.peak, got.changed, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, meter_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int counted;
    for (int m = 0; m < NumMeters; m++) begin
      target_lvl[m] = '0;
      bar_lvl[m]    = '0;
      peak_lvl[m]   = '0;
      hold_cnt[m]   = '0;
    end
    regs_m = '{decay: DecayStepRst, peak_decay: PeakDecayStepRst, hold: PeakHoldTicksRst};
    phase_regs[0] = regs_m;
    phase_regs[1] = '{decay: 16'hFFFF, peak_decay: 16'hFFFF, hold: 8'd0};
    phase_regs[2] = '{decay: 16'h0000, peak_decay: 16'h0000, hold: 8'hFF};
    phase_regs[3] = '{decay: level_t'($urandom_range(4000)),
                      peak_decay: level_t'($urandom_range(4000)),
                      hold: hold_t'($urandom_range(30))};
    phase_regs[4] = '{decay: 16'd1, peak_decay: 16'd1, hold: 8'd1};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowReg) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_word(dir_rows[i].func, dir_rows[i].chan, dir_rows[i].value);
        if (dir_rows[i].typed) begin
          meter_q[$].bar  = dir_rows[i].bar;
          meter_q[$].peak = dir_rows[i].peak;
        end
      end
    end

    for (int p = 0; p < 5; p++) begin
      apply_regs(phase_regs[p]);
      send_idle  = phase_send[p];
      recv_stall = phase_recv[p];
      counted = 0;
      while (counted < PhaseWords) begin
        // hold off until the bank has drained once
        if (p == 3 && counted == PhaseWords / 2) begin
          s_tvalid <= 1'b0;
          @(posedge clk_i);
          while (meter_q.size() != 0) @(posedge clk_i);
        end
        begin
          int before_drop;
          before_drop = n_dropped;
          send_random();
          if (n_dropped == before_drop) counted++;
        end
      end
    end

    wait_idle();
    $display("sent %0d readings, %0d ticks, %0d words for absent meters", n_readings,
             n_ticks, n_dropped);
    $display("checked %0d result words across %0d register settings", n_results,
             n_settings + 1);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
